// ===== hdl/lpd_pkg.sv =====
package lpd_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 128;
  localparam int VALUE_BITS = 16;

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_e;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // One column of the window plus the decisions it finalizes.
  typedef struct packed {
    value_t           older;
    value_t           newer;
    value_t           sample;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       emit;
    logic             up_prev;
    logic             up_cur;
    logic             left_prev;
    logic             left_cur;
  } col_item_t;

endpackage

// ===== hdl/lpd_front.sv =====
module lpd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lpd_pkg::value_t               sample_value_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output lpd_pkg::col_item_t            push_item_o
);
  import lpd_pkg::*;

  logic [CFG_W-1:0] row_count_q, col_count_q;
  logic [ROW_W-1:0] row_q, row_d, row_last;
  logic [COL_W-1:0] col_q, col_d, col_last;
  logic             accept, last_col, last_row;

  value_t           mem0 [MAX_COLS];
  value_t           mem1 [MAX_COLS];
  value_t           rd0_q, rd1_q;

  logic             s1_valid_q;
  value_t           s1_sample_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic [3:0]       s1_emit_q;
  logic [3:0]       emit_d;

  assign row_last = (row_count_q == '0) ? '0 :
                    (32'(row_count_q) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS - 1) :
                    ROW_W'(row_count_q - 1'b1);
  assign col_last = (col_count_q == '0) ? '0 :
                    (32'(col_count_q) > 32'(MAX_COLS)) ? COL_W'(MAX_COLS - 1) :
                    COL_W'(col_count_q - 1'b1);

  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last_col   = (col_q == col_last);
  assign last_row   = (row_q == row_last);

  assign emit_d[0] = (row_q != '0) && (col_q != '0);
  assign emit_d[1] = (row_q != '0) && last_col;
  assign emit_d[2] = last_row && (col_q != '0);
  assign emit_d[3] = last_row && last_col;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CFG_W'(MAX_ROWS);
      col_count_q <= CFG_W'(MAX_COLS);
      row_q       <= '0;
      col_q       <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ROW_COUNT) row_count_q <= cfg_data_i;
        if (cfg_idx_i == REG_COL_COUNT) col_count_q <= cfg_data_i;
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (push_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Rows alternate between the two banks by row parity.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0_q       <= mem0[col_q];
      rd1_q       <= mem1[col_q];
      s1_sample_q <= sample_value_i;
      s1_row_q    <= row_q;
      s1_col_q    <= col_q;
      s1_emit_q   <= emit_d;
      if (row_q[0]) begin
        mem1[col_q] <= sample_value_i;
      end else begin
        mem0[col_q] <= sample_value_i;
      end
    end
  end

  assign push_valid_o          = s1_valid_q;
  assign push_item_o.older     = s1_row_q[0] ? rd1_q : rd0_q;
  assign push_item_o.newer     = s1_row_q[0] ? rd0_q : rd1_q;
  assign push_item_o.sample    = s1_sample_q;
  assign push_item_o.row       = s1_row_q;
  assign push_item_o.col       = s1_col_q;
  assign push_item_o.emit      = s1_emit_q;
  assign push_item_o.up_prev   = (s1_row_q > ROW_W'(1));
  assign push_item_o.up_cur    = (s1_row_q != '0);
  assign push_item_o.left_prev = (s1_col_q > COL_W'(1));
  assign push_item_o.left_cur  = (s1_col_q != '0);

endmodule

// ===== hdl/lpd_fifo.sv =====
module lpd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  lpd_pkg::col_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output lpd_pkg::col_item_t pop_item_o
);
  import lpd_pkg::*;

  col_item_t          store_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) store_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== hdl/lpd_back.sv =====
module lpd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  lpd_pkg::col_item_t        pop_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lpd_pkg::ROW_W-1:0] elem_row_o,
  output logic [lpd_pkg::COL_W-1:0] elem_col_o,
  output lpd_pkg::value_t           elem_value_o,
  output logic                      is_peak_o,
  output logic                      frame_had_peak_o,
  output logic                      frame_last_o
);
  import lpd_pkg::*;

  value_t           win_q [3][3];
  value_t           pad   [4][4];
  logic [3:0]       pend_q, lowbit;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             up_prev_q, up_cur_q, left_prev_q, left_cur_q;
  logic             peak_seen_q;
  logic [1:0]       sel;
  logic             pop, out_fire, peak;
  value_t           center;

  assign lowbit      = pend_q & (~pend_q + 4'd1);
  assign out_valid_o = (pend_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign pop_ready_o = (pend_q == '0) || (((pend_q & ~lowbit) == '0) && out_ready_i);
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        pad[r][c] = (r < 3 && c < 3) ? win_q[r % 3][c % 3] : '0;
      end
    end
  end

  // sel bit 1: decided row is the current row; bit 0: decided column is the current one.
  always_comb begin
    logic [1:0] rb, cb;
    logic       up, dn, lf, rt, ok;
    rb     = {1'b0, sel[1]};
    cb     = {1'b0, sel[0]};
    up     = sel[1] ? up_cur_q : up_prev_q;
    lf     = sel[0] ? left_cur_q : left_prev_q;
    dn     = !sel[1];
    rt     = !sel[0];
    center = pad[rb + 2'd1][cb + 2'd1];
    peak   = 1'b1;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        ok = !(dr == 1 && dc == 1) && (dr != 0 || up) && (dr != 2 || dn) &&
             (dc != 0 || lf) && (dc != 2 || rt);
        if (ok && !(center > pad[rb + 2'(dr)][cb + 2'(dc)])) peak = 1'b0;
      end
    end
  end

  assign elem_row_o       = sel[1] ? row_q : row_q - 1'b1;
  assign elem_col_o       = sel[0] ? col_q : col_q - 1'b1;
  assign elem_value_o     = center;
  assign is_peak_o        = peak;
  assign frame_last_o     = (sel == 2'd3);
  assign frame_had_peak_o = frame_last_o && (peak_seen_q || peak);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      peak_seen_q <= 1'b0;
    end else begin
      if (pop) begin
        pend_q <= pop_item_i.emit;
      end else if (out_fire) begin
        pend_q <= pend_q & ~lowbit;
      end
      if (cfg_we_i) begin
        peak_seen_q <= 1'b0;
      end else if (out_fire) begin
        peak_seen_q <= frame_last_o ? 1'b0 : (peak_seen_q || peak);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= pop_item_i.older;
      win_q[1][2] <= pop_item_i.newer;
      win_q[2][2] <= pop_item_i.sample;
      row_q       <= pop_item_i.row;
      col_q       <= pop_item_i.col;
      up_prev_q   <= pop_item_i.up_prev;
      up_cur_q    <= pop_item_i.up_cur;
      left_prev_q <= pop_item_i.left_prev;
      left_cur_q  <= pop_item_i.left_cur;
    end
  end

endmodule

// ===== hdl/local_peak_detect_3x3.sv =====
// Each input passes the front-end stage register and column queue before the back end.
// Throughput: 1 element per cycle while each gives at most one result and out_ready_i is
// high; a last-column or last-row element gives up to two results, the final element of
// a frame up to 4, which the single result port offers one at a time.
// A 4-entry column queue sits between the line-store front end and the window back end.
// Reset (async, active low): sizes 128x128, position row 0 col 0; line stores not cleared.
module local_peak_detect_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lpd_pkg::value_t               sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpd_pkg::ROW_W-1:0]     elem_row_o,
  output logic [lpd_pkg::COL_W-1:0]     elem_col_o,
  output lpd_pkg::value_t               elem_value_o,
  output logic                          is_peak_o,
  output logic                          frame_had_peak_o,
  output logic                          frame_last_o
);
  import lpd_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  col_item_t push_item, pop_item;

  lpd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .sample_value_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  lpd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  lpd_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o,
    .out_ready_i,
    .elem_row_o,
    .elem_col_o,
    .elem_value_o,
    .is_peak_o,
    .frame_had_peak_o,
    .frame_last_o
  );

endmodule

// ===== hdl/lpd_checker.sv =====
module lpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [lpd_pkg::ROW_W-1:0]     elem_row_o,
  input logic [lpd_pkg::COL_W-1:0]     elem_col_o,
  input lpd_pkg::value_t               elem_value_o,
  input logic                          is_peak_o,
  input logic                          frame_had_peak_o,
  input logic                          frame_last_o
);
  import lpd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(elem_row_o) &&
    $stable(elem_col_o) && $stable(elem_value_o) && $stable(is_peak_o) &&
    $stable(frame_last_o) && $stable(frame_had_peak_o))
    else $error("result transaction changed while stalled");

  a_flag_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_had_peak_o |-> frame_last_o)
    else $error("frame_had_peak outside last result");

  a_last_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o && is_peak_o |-> frame_had_peak_o)
    else $error("peak on last result not reported for frame");

  a_peak_carried: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && is_peak_o && !frame_last_o && !cfg_we_i
    ##1 (out_valid_o && frame_last_o && !cfg_we_i) |-> frame_had_peak_o)
    else $error("peak of previous result lost at frame end");

endmodule

bind local_peak_detect_3x3 lpd_checker u_lpd_checker (.*);
